// File: hdl/tkh_pkg.sv
// Shared types and constants for the tilt-to-key converter.
package tkh_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DZ_BITS     = 13;
    localparam int NUM_KEYS    = 6;
    localparam int CFG_IDX_BITS = 2;
    localparam int WIDE_BITS   = ((SAMPLE_BITS > DZ_BITS + 1) ? SAMPLE_BITS : DZ_BITS + 1) + 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WIDE_BITS-1:0]   wide_t;
    typedef logic        [DZ_BITS-1:0]     dz_t;
    typedef logic        [NUM_KEYS-1:0]    key_mask_t;
    typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

    typedef enum logic [2:0] {
        KEY_LEFT      = 3'd0,
        KEY_RIGHT     = 3'd1,
        KEY_DOWN      = 3'd2,
        KEY_UP        = 3'd3,
        KEY_ALT_LEFT  = 3'd4,
        KEY_ALT_RIGHT = 3'd5
    } key_code_t;

    localparam cfg_idx_t CFG_DEAD_ZONE_X = 2'd0;
    localparam cfg_idx_t CFG_DEAD_ZONE_Y = 2'd1;
    localparam cfg_idx_t CFG_DEAD_ZONE_Z = 2'd2;

    localparam dz_t DZ_X_RESET = 13'd164;
    localparam dz_t DZ_Y_RESET = 13'd410;
    localparam dz_t DZ_Z_RESET = 13'd410;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

// File: hdl/tkh_if.sv
// Valid/ready channel interfaces for accelerometer samples and key events.
interface tkh_sample_if import tkh_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface tkh_event_if import tkh_pkg::*; ();
    logic      valid;
    logic      ready;
    key_code_t key_code;
    logic      is_press;
    logic      last_event;

    modport source (output valid, output key_code, output is_press, output last_event,
                    input ready);
    modport sink   (input valid, input key_code, input is_press, input last_event,
                    output ready);
endinterface

// File: hdl/tilt_to_key_hysteresis.sv
// Tilt-to-key converter: accelerometer samples in, key press/release events out.
// With no events pending, a sample passes through the input register and then the
// pending-event mask register before its first event is offered.
// One sample per cycle when it causes at most one event and key_evt.ready holds;
// otherwise the single-event output port drains the mask and holds samples back.
// Reset: centres zero, all keys released, dead zones 164/410/410, channels empty.
module tilt_to_key_hysteresis import tkh_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tkh_sample_if.sink      accel,
    tkh_event_if.source     key_evt,
    input  logic            cfg_we,
    input  cfg_idx_t        cfg_index,
    input  dz_t             cfg_data
);

    typedef struct packed {
        logic    low;
        logic    high;
        sample_t centre;
    } axis_res_t;

    function automatic sample_t sat_sample(wide_t v);
        if (v > wide_t'(SAMPLE_MAX))
            return SAMPLE_MAX;
        else if (v < wide_t'(SAMPLE_MIN))
            return SAMPLE_MIN;
        else
            return sample_t'(v);
    endfunction

    function automatic axis_res_t axis_step(sample_t a, sample_t c, dz_t d);
        axis_res_t r;
        wide_t     aw;
        wide_t     cw;
        wide_t     dw;
        wide_t     dw2;
        wide_t     c1w;
        sample_t   c1;
        aw  = wide_t'(a);
        cw  = wide_t'(c);
        dw  = wide_t'(d);
        dw2 = dw + dw;
        r.low = (aw < cw - dw);
        c1  = (aw < cw - dw2) ? sat_sample(aw + dw2) : c;
        c1w = wide_t'(c1);
        r.high = (aw > c1w + dw);
        r.centre = (aw > c1w + dw2) ? sat_sample(aw - dw2) : c1;
        return r;
    endfunction

    dz_t       dz_x_reg, dz_y_reg, dz_z_reg;
    logic      in_valid_reg;
    sample_t   ax_reg, ay_reg, az_reg;
    sample_t   cx_reg, cy_reg, cz_reg;
    key_mask_t held_reg;
    key_mask_t pend_reg;
    key_mask_t press_reg;

    axis_res_t rx, ry, rz;
    key_mask_t held_next;
    key_mask_t pend_next;
    logic      out_fire;
    logic      advance;
    key_code_t code;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_x_reg <= DZ_X_RESET;
            dz_y_reg <= DZ_Y_RESET;
            dz_z_reg <= DZ_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE_X: dz_x_reg <= cfg_data;
                CFG_DEAD_ZONE_Y: dz_y_reg <= cfg_data;
                CFG_DEAD_ZONE_Z: dz_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // axis evaluation from the input register
    always_comb
    begin
        rx = axis_step(ax_reg, cx_reg, dz_x_reg);
        ry = axis_step(ay_reg, cy_reg, dz_y_reg);
        rz = axis_step(az_reg, cz_reg, dz_z_reg);
        held_next = {rz.high, rz.low, ry.high, ry.low, rx.high, rx.low};
    end

    assign out_fire  = key_evt.valid && key_evt.ready;
    assign pend_next = out_fire ? (pend_reg & (pend_reg - key_mask_t'(1))) : pend_reg;
    assign advance   = in_valid_reg && (pend_next == '0);
    assign accel.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accel.ready)
        begin
            in_valid_reg <= accel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accel.ready && accel.valid)
        begin
            ax_reg <= accel.accel_x;
            ay_reg <= accel.accel_y;
            az_reg <= accel.accel_z;
        end
    end

    // state and pending event mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            held_reg  <= '0;
            pend_reg  <= '0;
            press_reg <= '0;
        end
        else if (advance)
        begin
            cx_reg    <= rx.centre;
            cy_reg    <= ry.centre;
            cz_reg    <= rz.centre;
            held_reg  <= held_next;
            pend_reg  <= held_next ^ held_reg;
            press_reg <= held_next;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // lowest pending key goes out first
    always_comb
    begin
        code = KEY_LEFT;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                code = key_code_t'(i);
        end
    end

    assign key_evt.valid      = (pend_reg != '0);
    assign key_evt.key_code   = code;
    assign key_evt.is_press   = press_reg[code];
    assign key_evt.last_event = ((pend_reg & (pend_reg - key_mask_t'(1))) == '0);

endmodule

// File: tb/tb_tilt_to_key_hysteresis.sv
// Self-checking testbench for tilt_to_key_hysteresis: tilt samples in, predicted key events checked out.
module tb_tilt_to_key_hysteresis;
    import tkh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int SEND_IDLE_PCT [4] = '{0, 57, 0, 30};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 57, 30};
    localparam cfg_idx_t CFG_UNUSED = 2'd3;
    localparam key_code_t LOW_KEY [3] = '{KEY_LEFT, KEY_DOWN, KEY_ALT_LEFT};
    localparam key_code_t HIGH_KEY[3] = '{KEY_RIGHT, KEY_UP, KEY_ALT_RIGHT};

    typedef struct {
        sample_t x;
        sample_t y;
        sample_t z;
        bit      drain_first;
    } sample_item_t;

    typedef struct {
        key_code_t code;
        bit        press;
        bit        last;
    } key_event_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    dz_t      cfg_data;

    tkh_sample_if accel_ch();
    tkh_event_if  key_ch();

    tilt_to_key_hysteresis u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accel     (accel_ch),
        .key_evt   (key_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tilt tracker state
    int        centre[3];
    dz_t       dead_zone[3];
    key_mask_t key_down;

    sample_item_t samples_pending[$];
    key_event_t   key_events_due[$];
    sample_item_t next_sample;
    key_event_t   due_event;
    int           tilt_level[3];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int n_samples;
    int n_presses;
    int n_releases;
    int n_settings;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_sample(int v);
        if (v > int'(SAMPLE_MAX))
            return int'(SAMPLE_MAX);
        if (v < int'(SAMPLE_MIN))
            return int'(SAMPLE_MIN);
        return v;
    endfunction

    function automatic void set_key(key_code_t k, bit down, ref key_event_t fresh[$]);
        key_event_t ev;
        if (down != key_down[k])
        begin
            key_down[k] = down;
            ev.code  = k;
            ev.press = down;
            ev.last  = 1'b0;
            fresh.push_back(ev);
        end
    endfunction

    function automatic void predict_key_events(sample_t sx, sample_t sy, sample_t sz);
        key_event_t fresh[$];
        key_event_t ev;
        sample_t    smp[3];
        int         a;
        int         d;
        smp = '{sx, sy, sz};
        for (int ax = 0; ax < 3; ax++)
        begin
            a = smp[ax];
            d = dead_zone[ax];
            set_key(LOW_KEY[ax], a < centre[ax] - d, fresh);
            if (a < centre[ax] - 2 * d)
                centre[ax] = clamp_sample(a + 2 * d);
            // high side sees the centre already dragged by the low side
            set_key(HIGH_KEY[ax], a > centre[ax] + d, fresh);
            if (a > centre[ax] + 2 * d)
                centre[ax] = clamp_sample(a - 2 * d);
        end
        foreach (fresh[i])
        begin
            ev      = fresh[i];
            ev.last = (i == fresh.size() - 1);
            key_events_due.push_back(ev);
        end
    endfunction

    // mostly gestures around a wandering level, some raw noise
    function automatic sample_t tilt_value(int ax);
        int span;
        int v;
        span = 3 * int'(dead_zone[ax]) + 2;
        if ($urandom_range(0, 99) < 15)
            return sample_t'($urandom);
        if ($urandom_range(0, 99) < 8)
            tilt_level[ax] = int'(sample_t'($urandom));
        v = tilt_level[ax] + int'($urandom_range(0, 2 * span)) - span;
        return sample_t'(clamp_sample(v));
    endfunction

    task automatic queue_sample(sample_t x, sample_t y, sample_t z, bit drain_first);
        sample_item_t it;
        it.x           = x;
        it.y           = y;
        it.z           = z;
        it.drain_first = drain_first;
        samples_pending.push_back(it);
    endtask

    task automatic write_reg(cfg_idx_t idx, dz_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DEAD_ZONE_X: dead_zone[0] = val;
            CFG_DEAD_ZONE_Y: dead_zone[1] = val;
            CFG_DEAD_ZONE_Z: dead_zone[2] = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(dz_t dz_x, dz_t dz_y, dz_t dz_z);
        write_reg(CFG_DEAD_ZONE_X, dz_x);
        write_reg(CFG_DEAD_ZONE_Y, dz_y);
        write_reg(CFG_DEAD_ZONE_Z, dz_z);
        write_reg(CFG_UNUSED, dz_t'($urandom));
        n_settings++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (samples_pending.size() > 0 || accel_ch.valid || key_events_due.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accel_ch.valid <= 1'b0;
        else if (!accel_ch.valid || accel_ch.ready)
        begin
            if (samples_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct
                && !(samples_pending[0].drain_first
                     && (accel_ch.valid || key_events_due.size() > 0)))
            begin
                next_sample      = samples_pending.pop_front();
                accel_ch.valid   <= 1'b1;
                accel_ch.accel_x <= next_sample.x;
                accel_ch.accel_y <= next_sample.y;
                accel_ch.accel_z <= next_sample.z;
            end
            else
                accel_ch.valid <= 1'b0;
        end
    end

    // event backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_ch.ready <= 1'b0;
        else
            key_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on sample transaction, check on event transaction
    always @(posedge clk)
    begin
        if (rst_n && accel_ch.valid && accel_ch.ready)
        begin
            predict_key_events(accel_ch.accel_x, accel_ch.accel_y, accel_ch.accel_z);
            n_samples++;
        end
        if (rst_n && key_ch.valid && key_ch.ready)
        begin
            if (key_events_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected event: expected none, actual key %0d press %0b last %0b",
                         $time, key_ch.key_code, key_ch.is_press, key_ch.last_event);
            end
            else
            begin
                due_event = key_events_due.pop_front();
                if (key_ch.key_code !== due_event.code || key_ch.is_press !== due_event.press
                    || key_ch.last_event !== due_event.last)
                begin
                    mismatches++;
                    $display("%0t: event mismatch: expected key %0d press %0b last %0b, actual key %0d press %0b last %0b",
                             $time, due_event.code, due_event.press, due_event.last,
                             key_ch.key_code, key_ch.is_press, key_ch.last_event);
                end
                if (due_event.press)
                    n_presses++;
                else
                    n_releases++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (accel_ch.valid && accel_ch.ready) || (key_ch.valid && key_ch.ready)
            || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d events still expected",
                     $time, key_events_due.size());
            $display("tilt_to_key_hysteresis regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_DEAD_ZONE_X;
        cfg_data         = '0;
        accel_ch.valid   = 1'b0;
        accel_ch.accel_x = '0;
        accel_ch.accel_y = '0;
        accel_ch.accel_z = '0;
        key_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatches       = 0;
        n_samples        = 0;
        n_presses        = 0;
        n_releases       = 0;
        n_settings       = 1;
        quiet_cycles     = 0;
        centre           = '{0, 0, 0};
        tilt_level       = '{0, 0, 0};
        key_down         = '0;
        dead_zone        = '{DZ_X_RESET, DZ_Y_RESET, DZ_Z_RESET};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset dead zones: full-scale swings, boundaries, return to rest
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_sample(-16'sd32768, 16'sd32767, -16'sd1, 1'b0);
        queue_sample(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
        queue_sample(-16'sd165, -16'sd411, 16'sd411, 1'b0);
        queue_sample(16'sd164, 16'sd410, -16'sd410, 1'b0);
        queue_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        queue_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        wait_quiet();

        // zero dead zone: any step off centre toggles keys
        configure('0, '0, '0);
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd1, -16'sd1, 16'sd0, 1'b0);
        queue_sample(-16'sd1, 16'sd1, 16'sd1, 1'b0);
        queue_sample(16'sd0, 16'sd0, -16'sd1, 1'b0);
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd1, 16'sd1, 16'sd1, 1'b0);
        wait_quiet();

        // widest dead zone, centre pushed toward the range limits
        configure('1, '1, '1);
        queue_sample(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
        queue_sample(-16'sd32768, 16'sd32767, 16'sd16382, 1'b0);
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_sample(-16'sd16383, 16'sd16383, -16'sd16382, 1'b0);
        queue_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_quiet();
            case (ph)
                0: configure(DZ_X_RESET, DZ_Y_RESET, DZ_Z_RESET);
                1: configure(dz_t'($urandom_range(0, 1000)), dz_t'($urandom_range(0, 1000)),
                             dz_t'($urandom_range(0, 1000)));
                2: configure('1, '0, dz_t'($urandom));
                default: configure(dz_t'($urandom_range(0, 64)), dz_t'($urandom_range(0, 64)),
                                   dz_t'($urandom_range(0, 64)));
            endcase
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_sample(tilt_value(0), tilt_value(1), tilt_value(2),
                             $urandom_range(0, 24) == 0);
        end
        wait_quiet();

        $display("Covered %0d samples over %0d dead-zone settings and four handshake mixes,",
                 n_samples, n_settings);
        $display("checking %0d key presses and %0d key releases.", n_presses, n_releases);
        if (mismatches == 0 && key_events_due.size() == 0)
            $display("tilt_to_key_hysteresis regression: pass");
        else
            $display("tilt_to_key_hysteresis regression: fail");
        $finish;
    end

endmodule
